// ===== src/i2cm_pkg.sv =====
// ============================================================================
// I2C register access master package
// Shared types, codes and decode helpers for the bus waveform engine.
// ============================================================================
package i2cm_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UPDATE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_HALF_BIT = 1'b1;

    localparam logic [6:0]  DEV_ADDR_RESET = 7'd41;
    localparam logic [15:0] HALF_BIT_RESET = 16'd250;

    // Program lengths in segments.
    localparam logic [3:0] LEN_WRITE  = 4'd5;
    localparam logic [3:0] LEN_READ   = 4'd8;
    localparam logic [3:0] LEN_UPDATE = 4'd13;
    localparam logic [3:0] UPD_WRITE_BASE = 4'd8;

    // Slot counts per segment kind.
    localparam logic [4:0] SLOTS_START = 5'd4;
    localparam logic [4:0] SLOTS_STOP  = 5'd3;
    localparam logic [4:0] SLOTS_RX    = 5'd19;
    localparam logic [4:0] SLOTS_TX    = 5'd26;

    // Slot positions with special meaning.
    localparam logic [4:0] TX_ACK_SLOT  = 5'd24;
    localparam logic [4:0] RX_DATA_END  = 5'd16;
    localparam logic [4:0] RX_NACK_HIGH = 5'd17;

    typedef enum logic [6:0] {
        SEG_START = 7'b0000001,
        SEG_STOP  = 7'b0000010,
        SEG_RX    = 7'b0000100,
        SEG_TX_W  = 7'b0001000,
        SEG_TX_R  = 7'b0010000,
        SEG_TX_I  = 7'b0100000,
        SEG_TX_D  = 7'b1000000
    } seg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] and_mask;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       nack_seen;
    } result_t;

    typedef struct packed {
        logic [2:0] bit_idx;
        logic [1:0] sub;
    } tx_pos_t;

    function automatic seg_t write_prog(input logic [3:0] ph);
        seg_t code;
        case (ph)
            4'd0:    code = SEG_START;
            4'd1:    code = SEG_TX_W;
            4'd2:    code = SEG_TX_I;
            4'd3:    code = SEG_TX_D;
            default: code = SEG_STOP;
        endcase
        return code;
    endfunction

    function automatic seg_t read_prog(input logic [3:0] ph);
        seg_t code;
        case (ph)
            4'd0:    code = SEG_START;
            4'd1:    code = SEG_TX_W;
            4'd2:    code = SEG_TX_I;
            4'd3:    code = SEG_STOP;
            4'd4:    code = SEG_START;
            4'd5:    code = SEG_TX_R;
            4'd6:    code = SEG_RX;
            default: code = SEG_STOP;
        endcase
        return code;
    endfunction

    // An update runs the read program and then the write program.
    function automatic seg_t seg_code(input logic [1:0] cmd, input logic [3:0] ph);
        seg_t code;
        if (cmd == CMD_WRITE)
            code = write_prog(ph);
        else if (ph < UPD_WRITE_BASE)
            code = read_prog(ph);
        else
            code = write_prog(ph - UPD_WRITE_BASE);
        return code;
    endfunction

    function automatic logic [3:0] prog_len(input logic [1:0] cmd);
        logic [3:0] len;
        case (cmd)
            CMD_WRITE: len = LEN_WRITE;
            CMD_READ:  len = LEN_READ;
            default:   len = LEN_UPDATE;
        endcase
        return len;
    endfunction

    function automatic logic [4:0] seg_slots(input seg_t code);
        logic [4:0] n;
        case (code)
            SEG_START: n = SLOTS_START;
            SEG_STOP:  n = SLOTS_STOP;
            SEG_RX:    n = SLOTS_RX;
            default:   n = SLOTS_TX;
        endcase
        return n;
    endfunction

    // Splits a transmit slot below the ack slot into bit number and phase within the bit.
    function automatic tx_pos_t tx_decode(input logic [4:0] s);
        tx_pos_t    p;
        logic [4:0] base;
        if (s >= 5'd21)      p.bit_idx = 3'd7;
        else if (s >= 5'd18) p.bit_idx = 3'd6;
        else if (s >= 5'd15) p.bit_idx = 3'd5;
        else if (s >= 5'd12) p.bit_idx = 3'd4;
        else if (s >= 5'd9)  p.bit_idx = 3'd3;
        else if (s >= 5'd6)  p.bit_idx = 3'd2;
        else if (s >= 5'd3)  p.bit_idx = 3'd1;
        else                 p.bit_idx = 3'd0;
        base  = 5'({2'b00, p.bit_idx}) + 5'({1'b0, p.bit_idx, 1'b0});
        p.sub = 2'(s - base);
        return p;
    endfunction

endpackage

// ===== src/i2cm_engine.sv =====
// ============================================================================
// I2C register access master engine
// Transaction state and the waveform step for each item.
// ============================================================================
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    input  logic [6:0]  device_address,
    input  logic [15:0] half_bit_cycles,
    output result_t     res
);

    logic       busy_reg, busy_next;
    logic [3:0] phase_reg, phase_next;
    logic [4:0] pos_reg, pos_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [1:0] hc_cmd_reg, hc_cmd_next;
    logic [7:0] hc_index_reg, hc_index_next;
    logic [7:0] hc_data_reg, hc_data_next;
    logic [7:0] hc_mask_reg, hc_mask_next;
    logic [7:0] rx_reg, rx_next;
    logic       nack_reg, nack_next;

    logic       accept;
    logic       e_busy;
    logic [3:0] e_phase;
    logic [4:0] e_pos;
    logic [15:0] e_cnt;
    logic       e_nack;
    seg_t       code;
    seg_t       new_code;
    tx_pos_t    txp;
    logic [15:0] hb;
    logic       last;
    logic       samp_ack;
    logic       samp_data;
    logic [4:0] pos_inc;
    logic [3:0] phase_inc;
    logic       scl;
    logic       sda;
    logic       drive;
    logic       done;

    assign accept = !busy_reg && (item.cmd != CMD_NONE);
    assign hb     = (half_bit_cycles == 16'd0) ? 16'd1 : half_bit_cycles;

    always_comb
    begin
        // Accepting a command starts the first START slot in the same cycle.
        hc_cmd_next   = accept ? item.cmd        : hc_cmd_reg;
        hc_index_next = accept ? item.reg_index  : hc_index_reg;
        hc_data_next  = accept ? item.write_data : hc_data_reg;
        hc_mask_next  = accept ? item.and_mask   : hc_mask_reg;
        e_busy  = busy_reg || accept;
        e_phase = accept ? 4'd0 : phase_reg;
        e_pos   = accept ? 5'd0 : pos_reg;
        e_cnt   = accept ? 16'd0 : cnt_reg;
        e_nack  = accept ? 1'b0 : nack_reg;

        code = seg_code(hc_cmd_next, e_phase);
        txp  = tx_decode(e_pos);
        last = ({1'b0, e_cnt} + 17'd1) >= {1'b0, hb};

        scl       = 1'b1;
        sda       = 1'b1;
        drive     = 1'b1;
        samp_ack  = 1'b0;
        samp_data = 1'b0;
        if (e_busy)
        begin
            case (code)
                SEG_START:
                begin
                    scl = e_pos < 5'd3;
                    sda = e_pos == 5'd0;
                end
                SEG_STOP:
                begin
                    scl = e_pos != 5'd0;
                    sda = e_pos == 5'd2;
                end
                SEG_RX:
                begin
                    if (e_pos < RX_DATA_END)
                    begin
                        scl       = !e_pos[0];
                        sda       = 1'b0;
                        drive     = 1'b0;
                        samp_data = !e_pos[0];
                    end
                    else
                    begin
                        scl = e_pos == RX_NACK_HIGH;
                        sda = 1'b1;
                    end
                end
                default:
                begin
                    if (e_pos < TX_ACK_SLOT)
                    begin
                        scl = txp.sub == 2'd1;
                        sda = shift_reg[3'd7 - txp.bit_idx];
                    end
                    else
                    begin
                        scl      = e_pos == TX_ACK_SLOT;
                        sda      = 1'b0;
                        drive    = 1'b0;
                        samp_ack = e_pos == TX_ACK_SLOT;
                    end
                end
            endcase
        end

        busy_next  = busy_reg;
        phase_next = e_phase;
        pos_next   = e_pos;
        cnt_next   = e_cnt;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        nack_next  = e_nack;
        done       = 1'b0;
        pos_inc    = e_pos + 5'd1;
        phase_inc  = e_phase + 4'd1;
        new_code   = seg_code(hc_cmd_next, phase_inc);
        if (e_busy)
        begin
            busy_next = 1'b1;
            if (last)
            begin
                if (samp_ack)
                    nack_next = e_nack | item.sda_in;
                else if (samp_data)
                    shift_next = {shift_reg[6:0], item.sda_in};
                pos_next = pos_inc;
                cnt_next = 16'd0;
                if (pos_inc >= seg_slots(code))
                begin
                    if (code == SEG_RX)
                        rx_next = shift_next;
                    if (phase_inc >= prog_len(hc_cmd_next))
                    begin
                        busy_next  = 1'b0;
                        phase_next = 4'd0;
                        pos_next   = 5'd0;
                        done       = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_inc;
                        pos_next   = 5'd0;
                        // The address is taken from the live register at each load.
                        case (new_code)
                            SEG_TX_W: shift_next = {device_address, 1'b0};
                            SEG_TX_R: shift_next = {device_address, 1'b1};
                            SEG_TX_I: shift_next = hc_index_next;
                            SEG_TX_D:
                            begin
                                if (hc_cmd_next == CMD_UPDATE)
                                    shift_next = (rx_next & hc_mask_next) | hc_data_next;
                                else
                                    shift_next = hc_data_next;
                            end
                            SEG_RX:   shift_next = 8'd0;
                            default:  shift_next = shift_next;
                        endcase
                    end
                end
            end
            else
            begin
                cnt_next = e_cnt + 16'd1;
            end
        end

        res.scl_level = scl;
        res.sda_level = sda;
        res.sda_drive = drive;
        res.busy_res  = e_busy;
        res.done_res  = done;
        res.read_byte = rx_next;
        res.nack_seen = nack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            phase_reg    <= 4'd0;
            pos_reg      <= 5'd0;
            cnt_reg      <= 16'd0;
            shift_reg    <= 8'd0;
            hc_cmd_reg   <= CMD_NONE;
            hc_index_reg <= 8'd0;
            hc_data_reg  <= 8'd0;
            hc_mask_reg  <= 8'd0;
            rx_reg       <= 8'd0;
            nack_reg     <= 1'b0;
        end
        else if (step)
        begin
            busy_reg     <= busy_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            shift_reg    <= shift_next;
            hc_cmd_reg   <= hc_cmd_next;
            hc_index_reg <= hc_index_next;
            hc_data_reg  <= hc_data_next;
            hc_mask_reg  <= hc_mask_next;
            rx_reg       <= rx_next;
            nack_reg     <= nack_next;
        end
    end

    // A START segment is four slots long, so a transaction never ends in its first item.
    a_accept_stays_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && accept |=> busy_reg)
        else $error("transaction ended in the item that started it");

    // The slot position always lies inside the current segment.
    a_pos_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg < seg_slots(seg_code(hc_cmd_reg, phase_reg)))
        else $error("slot position beyond segment length");

    // Idle leaves the sequencer at the start of its program.
    a_idle_rewound: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (phase_reg == 4'd0) && (pos_reg == 5'd0))
        else $error("sequencer not rewound while idle");

    // The finishing item leaves the engine idle.
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> !busy_reg)
        else $error("engine still busy after done");

endmodule

// ===== src/i2c_register_access_master_top.sv =====
// ============================================================================
// I2C register access master
// Bit-banged register write, read and read-modify-write over a two-wire bus.
// ============================================================================
// Each input item is one time step of the bus waveform and yields exactly one result
// item with the line levels for that step. An item is taken into an input register,
// goes through the waveform step of the engine and lands in a result register, so a
// new item is accepted every cycle while the result side does not stall. When the
// result side stalls, the input side stalls in turn once both registers hold an item.
// Commands are taken only while no transaction is running; one slot of the bus
// waveform lasts half_bit_cycles items (zero counts as one).
module i2c_register_access_master_top
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  and_mask,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_byte,
    output logic        nack_seen,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg;
    result_t     res;
    logic        advance;
    logic        take;
    logic [6:0]  dev_addr_reg;
    logic [15:0] half_bit_reg;

    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign take           = in_valid && !in_stall;
    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEV_ADDR_RESET;
            half_bit_reg <= HALF_BIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEV_ADDR: dev_addr_reg <= cfg_data[6:0];
                CFG_HALF_BIT: half_bit_reg <= cfg_data;
                default:      half_bit_reg <= half_bit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= '{cmd: cmd, reg_index: reg_index, write_data: write_data,
                          and_mask: and_mask, sda_in: sda_in};
        if (advance)
            res_reg <= res;
    end

    i2cm_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .item            (item_reg),
        .device_address  (dev_addr_reg),
        .half_bit_cycles (half_bit_reg),
        .res             (res)
    );

    assign out_valid = out_valid_reg;
    assign scl_level = res_reg.scl_level;
    assign sda_level = res_reg.sda_level;
    assign sda_drive = res_reg.sda_drive;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign read_byte = res_reg.read_byte;
    assign nack_seen = res_reg.nack_seen;

endmodule

// ===== tb/i2cm_bus_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C register access master bus checker
// Watches the item, result and register write ports of the master, predicts
// the line levels and status of every cycle, and compares each result item
// with the oldest prediction that is still waiting.
// ============================================================================
module i2cm_bus_checker
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  and_mask,
    input  logic        sda_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        scl_level,
    input  logic        sda_level,
    input  logic        sda_drive,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [7:0]  read_byte,
    input  logic        nack_seen,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    result_t     expected_lines[$];

    logic [6:0]  dev_addr_q;
    logic [15:0] half_bit_q;
    logic        busy_q;
    logic [3:0]  phase_q;
    logic [4:0]  slot_q;
    logic [15:0] slot_cnt_q;
    logic [7:0]  shreg_q;
    logic [1:0]  h_cmd;
    logic [7:0]  h_idx;
    logic [7:0]  h_data;
    logic [7:0]  h_mask;
    logic [7:0]  rx_byte_q;
    logic        nack_q;

    // A read runs two transfers; an update appends a write transfer after the read.
    function automatic seg_t segment_of(input logic [1:0] c, input logic [3:0] ph);
        logic [3:0] wp;
        seg_t       seg;
        wp = ph;
        if (c != CMD_WRITE && ph < 4'd8)
        begin
            case (ph)
                4'd0, 4'd4: seg = SEG_START;
                4'd1:       seg = SEG_TX_W;
                4'd2:       seg = SEG_TX_I;
                4'd5:       seg = SEG_TX_R;
                4'd6:       seg = SEG_RX;
                default:    seg = SEG_STOP;
            endcase
        end
        else
        begin
            if (c != CMD_WRITE)
                wp = ph - 4'd8;
            case (wp)
                4'd0:    seg = SEG_START;
                4'd1:    seg = SEG_TX_W;
                4'd2:    seg = SEG_TX_I;
                4'd3:    seg = SEG_TX_D;
                default: seg = SEG_STOP;
            endcase
        end
        return seg;
    endfunction

    function automatic int slots_in(input seg_t seg);
        case (seg)
            SEG_START: return 4;
            SEG_STOP:  return 3;
            SEG_RX:    return 19;
            default:   return 26;
        endcase
    endfunction

    function automatic int program_length(input logic [1:0] c);
        case (c)
            CMD_WRITE: return 5;
            CMD_READ:  return 8;
            default:   return 13;
        endcase
    endfunction

    // The address is taken from the register at the moment its byte is loaded.
    function automatic void load_segment();
        seg_t seg;
        seg = segment_of(h_cmd, phase_q);
        slot_q     = '0;
        slot_cnt_q = '0;
        case (seg)
            SEG_TX_W: shreg_q = {dev_addr_q, 1'b0};
            SEG_TX_R: shreg_q = {dev_addr_q, 1'b1};
            SEG_TX_I: shreg_q = h_idx;
            SEG_TX_D: shreg_q = (h_cmd == CMD_UPDATE) ? ((rx_byte_q & h_mask) | h_data) : h_data;
            SEG_RX:   shreg_q = '0;
            default:  ;
        endcase
    endfunction

    function automatic result_t bus_cycle(input item_t it);
        result_t     r;
        seg_t        seg;
        logic [15:0] span;
        logic        slot_end;
        logic [4:0]  s;
        logic [2:0]  bitn;
        logic        take_ack;
        logic        take_bit;
        r           = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.sda_drive = 1'b1;
        take_ack    = 1'b0;
        take_bit    = 1'b0;
        if (!busy_q && it.cmd != CMD_NONE)
        begin
            h_cmd   = it.cmd;
            h_idx   = it.reg_index;
            h_data  = it.write_data;
            h_mask  = it.and_mask;
            nack_q  = 1'b0;
            phase_q = '0;
            busy_q  = 1'b1;
            load_segment();
        end
        if (busy_q)
        begin
            seg        = segment_of(h_cmd, phase_q);
            s          = slot_q;
            span       = (half_bit_q == 16'd0) ? 16'd1 : half_bit_q;
            slot_end   = ({1'b0, slot_cnt_q} + 17'd1) >= {1'b0, span};
            r.busy_res = 1'b1;
            case (seg)
                SEG_START:
                begin
                    r.scl_level = (s < 3);
                    r.sda_level = (s == 0);
                end
                SEG_STOP:
                begin
                    r.scl_level = (s != 0);
                    r.sda_level = (s == 2);
                end
                SEG_RX:
                begin
                    if (s < 16)
                    begin
                        r.scl_level = ~s[0];
                        r.sda_level = 1'b0;
                        r.sda_drive = 1'b0;
                        take_bit    = ~s[0];
                    end
                    else
                    begin
                        // Master answers the byte with a NACK.
                        r.scl_level = (s == 17);
                        r.sda_level = 1'b1;
                    end
                end
                default:
                begin
                    if (s < 24)
                    begin
                        bitn        = 3'(s / 3);
                        r.scl_level = (s % 3 == 1);
                        r.sda_level = shreg_q[7 - bitn];
                    end
                    else
                    begin
                        r.scl_level = (s == 24);
                        r.sda_level = 1'b0;
                        r.sda_drive = 1'b0;
                        take_ack    = (s == 24);
                    end
                end
            endcase
            if (slot_end)
            begin
                if (take_ack)
                    nack_q = nack_q | it.sda_in;
                else if (take_bit)
                    shreg_q = {shreg_q[6:0], it.sda_in};
                slot_q     = slot_q + 5'd1;
                slot_cnt_q = '0;
                if (slot_q >= slots_in(seg))
                begin
                    if (seg == SEG_RX)
                        rx_byte_q = shreg_q;
                    phase_q = phase_q + 4'd1;
                    if (phase_q >= program_length(h_cmd))
                    begin
                        busy_q    = 1'b0;
                        phase_q   = '0;
                        slot_q    = '0;
                        r.done_res = 1'b1;
                    end
                    else
                        load_segment();
                end
            end
            else
                slot_cnt_q = slot_cnt_q + 16'd1;
        end
        r.read_byte = rx_byte_q;
        r.nack_seen = nack_q;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d, want %0d", $time, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            expected_lines.delete();
            dev_addr_q = DEV_ADDR_RESET;
            half_bit_q = HALF_BIT_RESET;
            busy_q     = 1'b0;
            phase_q    = '0;
            slot_q     = '0;
            slot_cnt_q = '0;
            shreg_q    = '0;
            h_cmd      = CMD_NONE;
            h_idx      = '0;
            h_data     = '0;
            h_mask     = '0;
            rx_byte_q  = '0;
            nack_q     = 1'b0;
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEV_ADDR)
                    dev_addr_q = cfg_data[6:0];
                else
                    half_bit_q = cfg_data;
            end
            // Results are checked before this edge's item is predicted, so a
            // result that nobody is waiting for cannot match a fresh prediction.
            if (out_valid && !out_stall)
            begin
                got = {scl_level, sda_level, sda_drive, busy_res, done_res, read_byte, nack_seen};
                if (expected_lines.size() == 0)
                    flag_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = expected_lines.pop_front();
                    if (got.scl_level !== want.scl_level)
                        flag_mismatch("scl_level", got.scl_level, want.scl_level);
                    if (got.sda_level !== want.sda_level)
                        flag_mismatch("sda_level", got.sda_level, want.sda_level);
                    if (got.sda_drive !== want.sda_drive)
                        flag_mismatch("sda_drive", got.sda_drive, want.sda_drive);
                    if (got.busy_res !== want.busy_res)
                        flag_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        flag_mismatch("done_res", got.done_res, want.done_res);
                    if (got.read_byte !== want.read_byte)
                        flag_mismatch("read_byte", got.read_byte, want.read_byte);
                    if (got.nack_seen !== want.nack_seen)
                        flag_mismatch("nack_seen", got.nack_seen, want.nack_seen);
                end
            end
            if (in_valid && !in_stall)
                expected_lines.push_back(bus_cycle({cmd, reg_index, write_data, and_mask, sda_in}));
            pending = expected_lines.size();
        end
    end

endmodule

// ===== tb/tb_i2c_register_access_master_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// I2C register access master testbench
// Drives write, read and update commands with random bus responses through
// several register settings, with random gaps and stalls on both channels,
// and reports the verdict from the bus checker's mismatch count.
// ============================================================================
module tb_i2c_register_access_master_top
    import i2cm_pkg::*;
();

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd        = CMD_NONE;
    logic [7:0]  reg_index  = '0;
    logic [7:0]  write_data = '0;
    logic [7:0]  and_mask   = '0;
    logic        sda_in     = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_byte;
    logic        nack_seen;
    logic        cfg_we     = 1'b0;
    logic        cfg_index  = CFG_DEV_ADDR;
    logic [15:0] cfg_data   = '0;

    int          mismatches;
    int          pending;
    bit          tx_calm    = 1'b1;
    bit          rx_calm    = 1'b1;
    int          stall_left = 0;

    i2c_register_access_master_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .reg_index  (reg_index),
        .write_data (write_data),
        .and_mask   (and_mask),
        .sda_in     (sda_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_drive  (sda_drive),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_byte  (read_byte),
        .nack_seen  (nack_seen),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    i2cm_bus_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .reg_index  (reg_index),
        .write_data (write_data),
        .and_mask   (and_mask),
        .sda_in     (sda_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_drive  (sda_drive),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_byte  (read_byte),
        .nack_seen  (nack_seen),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("** i2c_register_access_master_top: FAILED **");
        $finish;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!rx_calm)
                stall_left = pick_gap();
        end
    end

    function automatic logic sda_pick(input int mode);
        if (mode == 0)
            return 1'b0;
        if (mode == 1)
            return 1'b1;
        return 1'($urandom);
    endfunction

    task automatic send_item(input logic [1:0] c, input logic [7:0] idx, input logic [7:0] d,
                             input logic [7:0] m, input logic s);
        int n;
        n = tx_calm ? 0 : pick_gap();
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        cmd        <= c;
        reg_index  <= idx;
        write_data <= d;
        and_mask   <= m;
        sda_in     <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Items that only clock the bus; with busy_cmds set they also carry
    // commands that a running transaction has to ignore.
    task automatic fill(input int n, input int sda_mode, input bit busy_cmds);
        repeat (n)
            send_item(busy_cmds ? 2'($urandom_range(1, 3)) : CMD_NONE, 8'($urandom),
                      8'($urandom), 8'($urandom), sda_pick(sda_mode));
    endtask

    task automatic issue(input logic [1:0] c, input logic [7:0] idx, input logic [7:0] d,
                         input logic [7:0] m, input int sda_mode, input int n_fill);
        send_item(c, idx, d, m, sda_pick(sda_mode));
        fill(n_fill, sda_mode, 1'b0);
    endtask

    task automatic random_items(input int n);
        repeat (n)
            send_item(($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : CMD_NONE,
                      8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [6:0] addr, input logic [15:0] half_bit);
        drain();
        write_reg(CFG_DEV_ADDR, {9'd0, addr});
        write_reg(CFG_HALF_BIT, half_bit);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: idle lines, then the start of a write with long slots.
        issue(CMD_NONE, 8'h00, 8'h00, 8'h00, 0, 0);
        issue(CMD_WRITE, 8'h00, 8'h00, 8'h00, 0, 20);
        // Slot length drops to one in the middle of that transfer.
        set_config(7'd0, 16'd1);
        fill(90, 0, 1'b0);
        issue(CMD_WRITE, 8'hFF, 8'hFF, 8'h00, 1, 90);
        issue(CMD_READ, 8'h00, 8'h00, 8'hFF, 1, 115);
        issue(CMD_UPDATE, 8'hA5, 8'h00, 8'h00, 0, 200);
        issue(CMD_UPDATE, 8'h5A, 8'h0F, 8'hF0, 2, 0);
        fill(150, 2, 1'b1);
        fill(60, 2, 1'b0);
        // A slot length of zero behaves as one.
        set_config(7'd127, 16'd0);
        issue(CMD_READ, 8'h80, 8'h00, 8'h00, 2, 115);
        issue(CMD_WRITE, 8'h01, 8'h80, 8'h7F, 2, 90);
        set_config(7'd85, 16'hFFFF);
        issue(CMD_WRITE, 8'h3C, 8'hC3, 8'h00, 2, 10);

        set_config(7'($urandom_range(0, 127)), 16'd1);
        random_items(60);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        set_config(7'd127, 16'd2);
        random_items(60);
        set_config(7'($urandom_range(0, 127)), 16'hFFFF);
        random_items(20);
        tx_calm = 1'b1;
        set_config(7'($urandom_range(0, 127)), 16'd1);
        random_items(60);
        tx_calm = 1'b0;
        set_config(7'($urandom_range(0, 127)), 16'($urandom_range(1, 3)));
        random_items(50);
        drain();
        random_items(50);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("** i2c_register_access_master_top: PASSED **");
        else
            $display("** i2c_register_access_master_top: FAILED **");
        $finish;
    end

endmodule
